// ===== hw/rtl/bls_pkg.sv =====
`default_nettype none
package bls_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DATA_W = 64;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] DEPTH_SZ  = SIZE_W'(DEPTH);

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
  } ram_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] size;
    logic              rd;
  } rsp_meta_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bls_req_if.sv =====
`default_nettype none
interface bls_req_if import bls_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink (input valid, input mode, input value, input position, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bls_rsp_if.sv =====
`default_nettype none
interface bls_rsp_if import bls_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic [SIZE_W-1:0]        size;

  modport source (output valid, output data, output status, output size, input ready);
  modport sink (input valid, input data, input status, input size, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bounded_lifo_stack.sv =====
`default_nettype none
// Channel  Dir  Beat contents
// req      in   mode, value, position
// rsp      out  data, status, size
// cfg      in   cfg_we, cfg_wdata (capacity limit)
//
// A request beat updates the entry count and issues its memory access at the
// edge it is taken; its response beat moves from the pending stage into the output
// register when no stalled response holds it, and can then be taken.
// One beat per cycle is sustained while rsp is ready, set by the single
// memory port that each request uses once.
// Reset clears the entry count and sets the limit to 1024; the memory is not
// cleared. A stalled response holds the request stage, which drops req.ready.
module bounded_lifo_stack import bls_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  bls_req_if.sink                req,
  bls_rsp_if.source              rsp,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata
);

  logic                     accept;
  logic                     advance;
  logic                     pend;
  rsp_meta_t                pend_meta;
  rsp_meta_t                meta_in;
  ram_req_t                 ram_req;
  logic [DATA_W-1:0]        rdata;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic [STAT_W-1:0]        out_status;
  logic [SIZE_W-1:0]        out_size;

  assign advance   = pend && (!out_valid || rsp.ready);
  assign req.ready = !pend || advance;
  assign accept    = req.valid && req.ready;

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (req.mode),
    .position  (req.position),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .meta      (meta_in)
  );

  bls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (req.value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_meta <= meta_in;
    end
    if (advance) begin
      out_data   <= pend_meta.rd ? rdata : '0;
      out_status <= pend_meta.status;
      out_size   <= pend_meta.size;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;
  assign rsp.size   = out_size;

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.data == '0)
    else $error("Failed request returned nonzero data.");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.size <= DEPTH_SZ)
    else $error("Reported size exceeds the stack depth.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pend && !advance |=> pend && $stable(pend_meta))
    else $error("Pending request was lost while the response stalled.");

endmodule
`default_nettype wire

// ===== hw/rtl/bls_ram.sv =====
`default_nettype none
module bls_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bls_ctrl.sv =====
`default_nettype none
module bls_ctrl import bls_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  output ram_req_t               ram_req,
  output rsp_meta_t              meta
);

  logic [SIZE_W-1:0] count;
  logic [SIZE_W-1:0] count_next;
  logic [SIZE_W-1:0] capacity;
  logic [SIZE_W-1:0] lim_eff;
  logic [SIZE_W-1:0] pos_ext;
  logic [SIZE_W-1:0] count_dec;
  ram_req_t          req_raw;
  logic [STAT_W-1:0] status;
  logic              rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count <= count_next;
      end
    end
  end

  assign lim_eff   = (capacity > DEPTH_SZ) ? DEPTH_SZ : capacity;
  assign pos_ext   = SIZE_W'(position);
  assign count_dec = count - SIZE_W'(1);

  always_comb begin
    count_next = count;
    status     = ST_OK;
    rd         = 1'b0;
    req_raw    = '0;
    unique case (mode)
      MODE_PUSH: begin
        if (count >= lim_eff) begin
          status = ST_FULL;
        end else begin
          req_raw.en   = 1'b1;
          req_raw.we   = 1'b1;
          req_raw.addr = count[ADDR_W-1:0];
          count_next   = count + SIZE_W'(1);
        end
      end
      MODE_POP: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          req_raw.en   = 1'b1;
          req_raw.addr = count_dec[ADDR_W-1:0];
          rd           = 1'b1;
          count_next   = count_dec;
        end
      end
      MODE_READ: begin
        if (pos_ext >= count) begin
          status = ST_RANGE;
        end else begin
          req_raw.en   = 1'b1;
          req_raw.addr = ADDR_W'(position);
          rd           = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (pos_ext >= count) begin
          status = ST_RANGE;
        end else begin
          req_raw.en   = 1'b1;
          req_raw.we   = 1'b1;
          req_raw.addr = ADDR_W'(position);
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    ram_req    = req_raw;
    ram_req.en = req_raw.en & accept;
  end

  assign meta.status = status;
  assign meta.size   = count_next;
  assign meta.rd     = rd;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_SZ)
    else $error("Entry count exceeds the stack depth.");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_PUSH && status == ST_OK |=> count == $past(count) + SIZE_W'(1))
    else $error("Accepted push did not grow the stack by one entry.");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_POP && status == ST_OK |=> count == $past(count) - SIZE_W'(1))
    else $error("Accepted pop did not shrink the stack by one entry.");

endmodule
`default_nettype wire

// ===== tb/lifo_reply_checker.sv =====
`timescale 1ns / 100ps
module lifo_reply_checker import bls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bls_req_if                req,
  bls_rsp_if                rsp,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                mismatches,
  output int                outstanding,
  output logic [SIZE_W-1:0] entries
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [SIZE_W-1:0]        size;
  } stack_reply_t;

  stack_reply_t             pending_replies[$];
  logic signed [DATA_W-1:0] word_mem [DEPTH];
  logic [SIZE_W-1:0]        cap_limit;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    entries     = '0;
    cap_limit   = CAP_RESET;
  end

  task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
                                 input logic signed [DATA_W-1:0] want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic stack_reply_t stack_apply(input logic [MODE_W-1:0] m,
                                               input logic signed [DATA_W-1:0] v,
                                               input logic [POS_W-1:0] p);
    stack_reply_t      r;
    logic [SIZE_W-1:0] lim;
    r   = '0;
    lim = (cap_limit > DEPTH_SZ) ? DEPTH_SZ : cap_limit;
    case (m)
      MODE_PUSH: begin
        if (entries >= lim) begin
          r.status = ST_FULL;
        end else begin
          word_mem[entries[ADDR_W-1:0]] = v;
          entries = entries + SIZE_W'(1);
        end
      end
      MODE_POP: begin
        if (entries == '0) begin
          r.status = ST_EMPTY;
        end else begin
          entries = entries - SIZE_W'(1);
          r.data = word_mem[entries[ADDR_W-1:0]];
        end
      end
      MODE_READ: begin
        if (SIZE_W'(p) >= entries) r.status = ST_RANGE;
        else r.data = word_mem[p];
      end
      default: begin
        if (SIZE_W'(p) >= entries) r.status = ST_RANGE;
        else word_mem[p] = v;
      end
    endcase
    r.size = entries;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stack_reply_t want;
    if (rst) begin
      entries   = '0;
      cap_limit = CAP_RESET;
      pending_replies.delete();
    end else begin
      if (cfg_we) cap_limit = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unrequested response beat, data", rsp.data, '0);
        end else begin
          want = pending_replies.pop_front();
          if (rsp.data !== want.data) report_mismatch("data", rsp.data, want.data);
          if (rsp.status !== want.status) begin
            report_mismatch("status", DATA_W'(rsp.status), DATA_W'(want.status));
          end
          if (rsp.size !== want.size) begin
            report_mismatch("size", DATA_W'(rsp.size), DATA_W'(want.size));
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_replies.push_back(stack_apply(req.mode, req.value, req.position));
      end
    end
    outstanding = pending_replies.size();
  end

endmodule

// ===== tb/bounded_lifo_stack_test.sv =====
`timescale 1ns / 100ps
module bounded_lifo_stack_test;
  import bls_pkg::*;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] WORD_ALT = 64'sh5555_5555_AAAA_AAAA;
  localparam logic [SIZE_W-1:0]        CAP_MAX  = 11'h7FF;
  localparam logic [POS_W-1:0]         POS_MAX  = 10'h3FF;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  int                fail_count;
  int                pending_beats;
  logic [SIZE_W-1:0] model_entries;

  bls_req_if req_ch ();
  bls_rsp_if rsp_ch ();

  bounded_lifo_stack u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lifo_reply_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (fail_count),
    .outstanding (pending_beats),
    .entries     (model_entries)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_PUSH;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b1;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_beat(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v,
                           input logic [POS_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= m;
    req_ch.value    <= v;
    req_ch.position <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_beat(input int push_w, input int pop_w, input int read_w);
    int                       pick;
    int                       reach;
    logic [MODE_W-1:0]        m;
    logic signed [DATA_W-1:0] v;
    logic [POS_W-1:0]         p;
    pick = $urandom_range(99);
    if (pick < push_w) m = MODE_PUSH;
    else if (pick < push_w + pop_w) m = MODE_POP;
    else if (pick < push_w + pop_w + read_w) m = MODE_READ;
    else m = MODE_WRITE;
    case ($urandom_range(9))
      0: v = WORD_MAX;
      1: v = WORD_MIN;
      2: v = -64'sd1;
      3: v = '0;
      default: v = {$urandom, $urandom};
    endcase
    reach = (model_entries >= 1023) ? 1023 : int'(model_entries) + 1;
    if ($urandom_range(3) == 0) p = POS_W'($urandom_range(1023));
    else p = POS_W'($urandom_range(reach));
    send_beat(m, v, p);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_beats != 0) @(negedge clk);
  endtask

  task automatic set_limit(input logic [SIZE_W-1:0] lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(MODE_POP, '0, '0);
    send_beat(MODE_READ, '0, '0);
    send_beat(MODE_WRITE, WORD_MAX, POS_MAX);
    send_beat(MODE_PUSH, WORD_MAX, '0);
    send_beat(MODE_PUSH, WORD_MIN, POS_MAX);
    send_beat(MODE_PUSH, -64'sd1, '0);
    send_beat(MODE_PUSH, '0, '0);
    send_beat(MODE_READ, '0, '0);
    send_beat(MODE_READ, '0, 10'd3);
    send_beat(MODE_READ, '0, 10'd4);
    send_beat(MODE_READ, '0, POS_MAX);
    send_beat(MODE_WRITE, WORD_ALT, 10'd1);
    send_beat(MODE_WRITE, WORD_ALT, 10'd4);
    send_beat(MODE_POP, '0, '0);
    send_beat(MODE_POP, '0, '0);
    send_beat(MODE_POP, '0, '0);

    // The limit drops to the held count: pushes must be refused.
    set_limit(11'd1);
    send_beat(MODE_PUSH, WORD_ALT, '0);
    send_beat(MODE_POP, '0, '0);
    send_beat(MODE_PUSH, WORD_MIN, '0);
    send_beat(MODE_PUSH, WORD_MAX, '0);

    set_limit('0);
    send_beat(MODE_PUSH, -64'sd1, '0);
    send_beat(MODE_POP, '0, '0);
    send_beat(MODE_PUSH, -64'sd1, '0);

    set_limit(11'd40);
    repeat (40) random_beat(55, 20, 13);

    set_limit(11'd8);
    send_idle_pct = 63;
    for (n = 0; n < 40; n++) begin
      if (n == 20) drain();
      random_beat(25, 45, 15);
    end

    set_limit(SIZE_W'($urandom_range(1, 16)));
    send_idle_pct = 0;
    stall_pct     = 63;
    repeat (40) random_beat(40, 30, 15);

    // A limit above the depth saturates, so the stack fills to its depth.
    set_limit(CAP_MAX);
    send_idle_pct = 20;
    stall_pct     = 20;
    while (model_entries < DEPTH_SZ) random_beat(95, 0, 3);
    repeat (3) send_beat(MODE_PUSH, WORD_MAX, '0);
    send_beat(MODE_READ, '0, POS_MAX);
    send_beat(MODE_WRITE, WORD_MIN, POS_MAX);
    send_beat(MODE_POP, '0, '0);
    repeat (20) random_beat(30, 40, 15);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
